// ===== hw/rtl/sitrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitrt_pkg: shared types and constants for the radix text converter
// Character codes, radix limits, digit encoding and store write word.
// ----------------------------------------------------------------------------
package sitrt_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_A     = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_NUL   = 8'h00;  // terminator

    localparam logic [4:0] RADIX_MIN  = 5'd2;
    localparam logic [4:0] RADIX_MAX  = 5'd16;
    localparam logic [3:0] DEC_MAX    = 4'd9;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    typedef logic [3:0] digit_t;

    // write word into the digit store
    typedef struct packed {
        logic   wr_en;
        digit_t wr_digit;
    } store_wr_t;

    function automatic logic [7:0] digit_char(input digit_t d);
        logic [7:0] dw;
        dw = {4'd0, d};
        if (d <= DEC_MAX)
        begin
            return CHAR_ZERO + dw;
        end
        return CHAR_A + dw - LETTER_OFS;
    endfunction

    // index of the most significant nonzero byte, 0 for a zero word
    function automatic logic [1:0] top_byte(input logic [31:0] w);
        priority if (w[31:24] != 8'd0)
        begin
            return 2'd3;
        end
        else if (w[23:16] != 8'd0)
        begin
            return 2'd2;
        end
        else if (w[15:8] != 8'd0)
        begin
            return 2'd1;
        end
        else
        begin
            return 2'd0;
        end
    endfunction

endpackage

// ===== hw/rtl/sitrt_div_step.sv =====
// ----------------------------------------------------------------------------
// sitrt_div_step: one byte of long division by the radix
// Eight restoring steps: quotient byte and running remainder.
// ----------------------------------------------------------------------------
module sitrt_div_step
    import sitrt_pkg::*;
(
    input  digit_t     rem_in,
    input  logic [7:0] chunk,
    input  logic [4:0] radix,
    output logic [7:0] quo,
    output digit_t     rem_out
);

    always_comb
    begin
        logic [4:0] r;
        r   = {1'b0, rem_in};
        quo = 8'd0;
        for (int i = 7; i >= 0; i--)
        begin
            // remainder stays below radix, so 2r+1 fits in 5 bits
            r = {r[3:0], chunk[i]};
            if (r >= radix)
            begin
                r      = r - radix;
                quo[i] = 1'b1;
            end
        end
        rem_out = r[3:0];
    end

endmodule

// ===== hw/rtl/sitrt_digit_store.sv =====
// ----------------------------------------------------------------------------
// sitrt_digit_store: digit register file
// Digits land least significant first and are read back in reverse.
// ----------------------------------------------------------------------------
module sitrt_digit_store
    import sitrt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IW    = 5
)
(
    input  logic          clk,
    input  store_wr_t     wr,
    input  logic [IW-1:0] wr_addr,
    input  logic [IW-1:0] rd_addr,
    output digit_t        rd_digit
);

    digit_t digits_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            digits_reg[wr_addr] <= wr.wr_digit;
        end
    end

    assign rd_digit = digits_reg[rd_addr];

endmodule

// ===== hw/rtl/signed_int_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text: signed 32-bit integer to ASCII text in radix 2..16
// Each digit runs its dividend through the shared byte divider from the top
//   nonzero byte down to byte 0; then one byte per cycle unless out_ready stalls.
// A new value is taken only in idle, once the terminator is loaded; longest
//   text is -2^31 in base 2 (32 digits, 34 bytes).
// Reset: rst_n clears sequencer and output valid; digit store is not cleared.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text
    import sitrt_pkg::*;
#(
    parameter int DIGIT_STORE = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic [4:0]  radix,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_last,
    output logic [5:0]  byte_count
);

    localparam int CW = $clog2(DIGIT_STORE + 1);  // digit count
    localparam int IW = $clog2(DIGIT_STORE);      // store index

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

    state_t        state_reg, state_next;
    logic [31:0]   mag_reg, mag_next;     // dividend of the current digit
    logic [31:0]   quo_reg, quo_next;     // quotient, built byte by byte
    logic [4:0]    radix_reg, radix_next;
    logic          neg_reg, neg_next;
    digit_t        rem_reg, rem_next;
    logic [1:0]    chunk_reg, chunk_next; // byte being divided
    logic [CW-1:0] n_reg, n_next;         // digits stored so far
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic          sign_pend_reg, sign_pend_next;
    logic [5:0]    total_reg, total_next; // byte count of the text in progress
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          is_last_reg, is_last_next;
    logic [5:0]    byte_count_reg, byte_count_next;

    // shared divider hookup
    logic [7:0]    div_quo;
    digit_t        div_rem;
    logic [31:0]   quo_now;
    logic [CW-1:0] n_inc;

    // store hookup
    store_wr_t     st_wr;
    logic [CW-1:0] emit_dec;
    digit_t        rd_digit;

    sitrt_div_step u_div (
        .rem_in  (rem_reg),
        .chunk   (mag_reg[{chunk_reg, 3'b000} +: 8]),
        .radix   (radix_reg),
        .quo     (div_quo),
        .rem_out (div_rem)
    );

    sitrt_digit_store #(
        .DEPTH (DIGIT_STORE),
        .IW    (IW)
    ) u_store (
        .clk      (clk),
        .wr       (st_wr),
        .wr_addr  (n_reg[IW-1:0]),
        .rd_addr  (emit_dec[IW-1:0]),
        .rd_digit (rd_digit)
    );

    assign emit_dec = emit_idx_reg - CW'(1);
    assign n_inc    = n_reg + CW'(1);

    always_comb
    begin
        quo_now = quo_reg;
        quo_now[{chunk_reg, 3'b000} +: 8] = div_quo;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        quo_next        = quo_reg;
        radix_next      = radix_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        n_next          = n_reg;
        emit_idx_next   = emit_idx_reg;
        sign_pend_next  = sign_pend_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_byte_next   = out_byte_reg;
        is_last_next    = is_last_reg;
        byte_count_next = byte_count_reg;
        st_wr.wr_en     = 1'b0;
        st_wr.wr_digit  = div_rem;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // magnitude: two's complement negate, 2^31 stays exact
                    mag_next   = value[31] ? (32'd0 - value) : value;
                    neg_next   = value[31];
                    priority if (radix < RADIX_MIN)
                    begin
                        radix_next = RADIX_MIN;
                    end
                    else if (radix > RADIX_MAX)
                    begin
                        radix_next = RADIX_MAX;
                    end
                    else
                    begin
                        radix_next = radix;
                    end
                    rem_next   = '0;
                    quo_next   = '0;
                    chunk_next = top_byte(value[31] ? (32'd0 - value) : value);
                    n_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_rem;
                quo_next = quo_now;
                if (chunk_reg == 2'd0)
                begin
                    // digit done: at least one digit even for zero
                    st_wr.wr_en = 1'b1;
                    n_next      = n_inc;
                    if (quo_now == 32'd0 || n_inc == CW'(DIGIT_STORE))
                    begin
                        state_next     = ST_EMIT;
                        sign_pend_next = neg_reg;
                        emit_idx_next  = n_inc;
                        total_next     = 6'(n_inc) + 6'd1 + {5'd0, neg_reg};
                    end
                    else
                    begin
                        mag_next   = quo_now;
                        quo_next   = '0;
                        rem_next   = '0;
                        chunk_next = top_byte(quo_now);
                    end
                end
                else
                begin
                    chunk_next = chunk_reg - 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    byte_count_next = total_reg;
                    priority if (sign_pend_reg)
                    begin
                        out_byte_next  = CHAR_MINUS;
                        is_last_next   = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else if (emit_idx_reg != '0)
                    begin
                        out_byte_next = digit_char(rd_digit);
                        is_last_next  = 1'b0;
                        emit_idx_next = emit_dec;
                    end
                    else
                    begin
                        out_byte_next = CHAR_NUL;
                        is_last_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        quo_reg        <= quo_next;
        radix_reg      <= radix_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        chunk_reg      <= chunk_next;
        n_reg          <= n_next;
        emit_idx_reg   <= emit_idx_next;
        sign_pend_reg  <= sign_pend_next;
        total_reg      <= total_next;
        out_byte_reg   <= out_byte_next;
        is_last_reg    <= is_last_next;
        byte_count_reg <= byte_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_last    = is_last_reg;
    assign byte_count = byte_count_reg;

`ifndef ASSERT_OFF
    // terminator word and only the terminator word carries a zero byte
    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> out_byte == CHAR_NUL)
        else $error("last word is not the terminator");

    a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> out_byte != CHAR_NUL)
        else $error("zero byte before the last word");

    // divider remainder must stay below the radix
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < radix_reg)
        else $error("remainder not below radix");

    // an accepted word blocks the input for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while converting");

    // sequencer never loads a new byte over a word still waiting
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_last)
            && $stable(byte_count))
        else $error("output word changed while stalled");
`endif

endmodule
